// File: rtl/rsm_pkg.sv
// Shared constants and codes for the RAID sector mapper.
`default_nettype none
package rsm_pkg;
	localparam int MAX_DISKS_DEF   = 16;
	localparam int SECTOR_BITS_DEF = 32;

	localparam int SECTOR_W  = 32;
	localparam int STRIPE_W  = 32;
	localparam int DISK_W    = 4;
	localparam int KIND_W    = 2;
	localparam int LEVEL_W   = 3;
	localparam int DCOUNT_W  = 5;
	localparam int CHUNK_W   = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_CHUNK = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DCOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK  = 2'd2;

	localparam logic [LEVEL_W-1:0] LVL_RAID0  = 3'd0;
	localparam logic [LEVEL_W-1:0] LVL_RAID1  = 3'd1;
	localparam logic [LEVEL_W-1:0] LVL_RAID01 = 3'd2;
	localparam logic [LEVEL_W-1:0] LVL_RAID10 = 3'd3;
	localparam logic [LEVEL_W-1:0] LVL_RAID4  = 3'd4;
	localparam logic [LEVEL_W-1:0] LVL_RAID5  = 3'd5;

	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MIRROR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PARITY = 2'd2;
endpackage
`default_nettype wire

// File: rtl/rsm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rsm_div #(
	parameter int DW  = 32,
	parameter int VW  = 13,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  logic [DW-1:0]  dividend,
	input  logic [VW-1:0]  divisor,
	input  logic [SBW-1:0] in_sb,
	output logic           out_vld,
	output logic [DW-1:0]  quotient,
	output logic [VW-1:0]  remainder,
	output logic [SBW-1:0] out_sb
);
	logic [DW-1:0]  num_s [DW+1];
	logic [DW-1:0]  quo_s [DW+1];
	logic [VW-1:0]  rem_s [DW+1];
	logic [SBW-1:0] sb_s  [DW+1];
	logic           vld_s [DW+1];

	assign num_s[0] = dividend;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign sb_s[0]  = in_sb;
	assign vld_s[0] = in_vld;

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic [VW:0]   sh;
		logic [VW:0]   diff;
		logic          ge;
		logic [VW-1:0] rem_n;

		// bring down the next dividend bit, subtract when it fits
		assign sh    = {rem_s[i], num_s[i][DW-1]};
		assign diff  = sh - {1'b0, divisor};
		assign ge    = (sh >= {1'b0, divisor});
		assign rem_n = ge ? diff[VW-1:0] : sh[VW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			num_s[i+1] <= num_s[i] << 1;
			quo_s[i+1] <= {quo_s[i][DW-2:0], ge};
			rem_s[i+1] <= rem_n;
			sb_s[i+1]  <= sb_s[i];
		end
	end

	assign out_vld   = vld_s[DW];
	assign quotient  = quo_s[DW];
	assign remainder = rem_s[DW];
	assign out_sb    = sb_s[DW];
endmodule
`default_nettype wire

// File: rtl/raid_sector_mapper_unit.sv
// Top level of the RAID sector mapper: config registers, two dividers, output stages.
// The path from start to done runs through two bit-per-stage divider pipelines,
// then a multiply stage and a finish stage.
// Throughput: one sector per cycle; busy stays low, the receiver cannot stall.
// Reset: arst_n clears the pipeline valid bits and loads level 0, two disks,
// one-sector chunks.
`default_nettype none
module raid_sector_mapper_unit #(
	parameter int MAX_DISKS   = rsm_pkg::MAX_DISKS_DEF,
	parameter int SECTOR_BITS = rsm_pkg::SECTOR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rsm_pkg::SECTOR_W-1:0]   sector,
	input  logic                           cfg_we,
	input  logic [rsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsm_pkg::CFG_W-1:0]      cfg_wdata,
	output logic                           done,
	output logic [rsm_pkg::DISK_W-1:0]     disk_index,
	output logic [rsm_pkg::STRIPE_W-1:0]   stripe_index,
	output logic [rsm_pkg::DISK_W-1:0]     companion_disk,
	output logic [rsm_pkg::KIND_W-1:0]     companion_kind
);
	import rsm_pkg::*;

	localparam int NW   = $clog2(MAX_DISKS + 1);
	localparam int CW   = CHUNK_W;
	localparam int SB2W = LEVEL_W + CW + SECTOR_BITS;

	// configuration registers
	logic [LEVEL_W-1:0]  level_q;
	logic [DCOUNT_W-1:0] dcount_q;
	logic [CHUNK_W-1:0]  chunk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= LVL_RAID0;
			dcount_q <= DCOUNT_W'(2);
			chunk_q  <= CHUNK_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL:  level_q  <= cfg_wdata[LEVEL_W-1:0];
				REG_DCOUNT: dcount_q <= cfg_wdata[DCOUNT_W-1:0];
				REG_CHUNK:  chunk_q  <= cfg_wdata[CHUNK_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp disk count and chunk size into their legal ranges
	logic [NW-1:0] n_eff;
	logic [NW-1:0] half;
	logic [NW-1:0] nm1;
	logic [CW-1:0] c_eff;

	always_comb begin
		if (dcount_q < DCOUNT_W'(2)) begin
			n_eff = NW'(2);
		end else if (32'(dcount_q) > MAX_DISKS) begin
			n_eff = NW'(MAX_DISKS);
		end else begin
			n_eff = NW'(dcount_q);
		end
		if (chunk_q == '0) begin
			c_eff = CW'(1);
		end else if (32'(chunk_q) > MAX_CHUNK) begin
			c_eff = CW'(MAX_CHUNK);
		end else begin
			c_eff = chunk_q;
		end
	end

	assign half = n_eff >> 1;
	assign nm1  = n_eff - NW'(1);

	// first divisor depends on the layout; raid1 divides by one to pass the sector
	logic [CW-1:0] div1;

	always_comb begin
		unique case (level_q)
			LVL_RAID0:              div1 = c_eff;
			LVL_RAID01, LVL_RAID10: div1 = CW'(half);
			LVL_RAID4, LVL_RAID5:   div1 = CW'(nm1);
			default:                div1 = CW'(1);
		endcase
	end

	assign busy = 1'b0;

	logic [SECTOR_BITS-1:0] blk;
	assign blk = SECTOR_BITS'(sector);

	// divider 1: sector by chunk size, half, n-1 or one
	logic                   v1;
	logic [SECTOR_BITS-1:0] q1;
	logic [CW-1:0]          r1;
	logic [LEVEL_W-1:0]     lvl1;

	rsm_div #(.DW(SECTOR_BITS), .VW(CW), .SBW(LEVEL_W)) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start),
		.dividend  (blk),
		.divisor   (div1),
		.in_sb     (level_q),
		.out_vld   (v1),
		.quotient  (q1),
		.remainder (r1),
		.out_sb    (lvl1)
	);

	// divider 2: first quotient by disk count (raid0 chunk row, raid5 parity turn)
	logic                   v2;
	logic [SECTOR_BITS-1:0] q2;
	logic [NW-1:0]          r2;
	logic [SB2W-1:0]        sb2;

	rsm_div #(.DW(SECTOR_BITS), .VW(NW), .SBW(SB2W)) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (v1),
		.dividend  (q1),
		.divisor   (n_eff),
		.in_sb     ({lvl1, r1, q1}),
		.out_vld   (v2),
		.quotient  (q2),
		.remainder (r2),
		.out_sb    (sb2)
	);

	// stage 1: multiply chunk row by chunk size, carry the rest
	logic                      vld_s1;
	logic [SECTOR_BITS+CW-1:0] prod_s1;
	logic [LEVEL_W-1:0]        lvl_s1;
	logic [CW-1:0]             r1_s1;
	logic [SECTOR_BITS-1:0]    q1_s1;
	logic [NW-1:0]             r2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (SECTOR_BITS+CW)'(q2) * (SECTOR_BITS+CW)'(c_eff);
		lvl_s1  <= sb2[SB2W-1 -: LEVEL_W];
		r1_s1   <= sb2[SECTOR_BITS +: CW];
		q1_s1   <= sb2[SECTOR_BITS-1:0];
		r2_s1   <= r2;
	end

	// stage 2: form the per-layout result
	logic [DISK_W-1:0]   disk_c;
	logic [STRIPE_W-1:0] stripe_c;
	logic [DISK_W-1:0]   comp_c;
	logic [KIND_W-1:0]   kind_c;
	logic [NW-1:0]       par_c;
	logic [NW:0]         rot_c;
	logic [NW:0]         rot_m;

	// raid5 left-symmetric: parity walks down, data starts just after it
	assign par_c = nm1 - r2_s1;
	assign rot_c = (NW+1)'(par_c) + (NW+1)'(1) + (NW+1)'(r1_s1);
	assign rot_m = (rot_c >= (NW+1)'(n_eff)) ? rot_c - (NW+1)'(n_eff) : rot_c;

	always_comb begin
		disk_c   = '0;
		stripe_c = '0;
		comp_c   = '0;
		kind_c   = KIND_NONE;
		unique case (lvl_s1)
			LVL_RAID0: begin
				disk_c   = DISK_W'(r2_s1);
				stripe_c = STRIPE_W'(prod_s1 + (SECTOR_BITS+CW)'(r1_s1));
			end
			LVL_RAID1: begin
				stripe_c = STRIPE_W'(q1_s1);
				comp_c   = DISK_W'(1);
				kind_c   = KIND_MIRROR;
			end
			LVL_RAID01: begin
				disk_c   = DISK_W'(r1_s1);
				comp_c   = DISK_W'(r1_s1 + CW'(half));
				stripe_c = STRIPE_W'(q1_s1);
				kind_c   = KIND_MIRROR;
			end
			LVL_RAID10: begin
				disk_c   = DISK_W'({r1_s1, 1'b0});
				comp_c   = DISK_W'({r1_s1, 1'b1});
				stripe_c = STRIPE_W'(q1_s1);
				kind_c   = KIND_MIRROR;
			end
			LVL_RAID4: begin
				disk_c   = DISK_W'(r1_s1);
				comp_c   = DISK_W'(nm1);
				stripe_c = STRIPE_W'(q1_s1);
				kind_c   = KIND_PARITY;
			end
			LVL_RAID5: begin
				disk_c   = DISK_W'(rot_m);
				comp_c   = DISK_W'(par_c);
				stripe_c = STRIPE_W'(q1_s1);
				kind_c   = KIND_PARITY;
			end
			default: ;
		endcase
	end

	logic                vld_s2;
	logic [DISK_W-1:0]   disk_s2;
	logic [STRIPE_W-1:0] stripe_s2;
	logic [DISK_W-1:0]   comp_s2;
	logic [KIND_W-1:0]   kind_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		disk_s2   <= disk_c;
		stripe_s2 <= stripe_c;
		comp_s2   <= comp_c;
		kind_s2   <= kind_c;
	end

	// one beat per strobe, no hold-off
	assign done           = vld_s2;
	assign disk_index     = disk_s2;
	assign stripe_index   = stripe_s2;
	assign companion_disk = comp_s2;
	assign companion_kind = kind_s2;
endmodule
`default_nettype wire

// File: rtl/rsm_check.sv
// Port-level checker for the RAID sector mapper, bound to the top level.
`default_nettype none
module rsm_check #(
	parameter int LAT = 2 * rsm_pkg::SECTOR_BITS_DEF + 2
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [rsm_pkg::SECTOR_W-1:0]  sector,
	input logic                          cfg_we,
	input logic [rsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rsm_pkg::CFG_W-1:0]     cfg_wdata,
	input logic                          done,
	input logic [rsm_pkg::DISK_W-1:0]    disk_index,
	input logic [rsm_pkg::STRIPE_W-1:0]  stripe_index,
	input logic [rsm_pkg::DISK_W-1:0]    companion_disk,
	input logic [rsm_pkg::KIND_W-1:0]    companion_kind
);
	import rsm_pkg::*;

	// every accepted beat comes out after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted sector produced no result");

	// no result without an accepted beat
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && companion_kind == KIND_NONE |-> companion_disk == '0)
		else $error("companion disk set without a companion");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> companion_kind == KIND_NONE || companion_kind == KIND_MIRROR ||
			companion_kind == KIND_PARITY)
		else $error("bad companion kind");
endmodule

bind raid_sector_mapper_unit rsm_check #(.LAT(2 * SECTOR_BITS + 2)) u_rsm_check (.*);
`default_nettype wire
